// ----- design/hrds_pkg.sv -----
// Shared types and constants for the HID report descriptor scanner.
// No dependencies; every other design file imports this package.
`default_nettype none

package hrds_pkg;

   // Item type codes of a short item prefix.
   localparam logic [1:0] TYPE_MAIN     = 2'd0;
   localparam logic [1:0] TYPE_GLOBAL   = 2'd1;
   localparam logic [1:0] TYPE_LOCAL    = 2'd2;
   localparam logic [1:0] TYPE_RESERVED = 2'd3;

   // Global item tags that are tracked.
   localparam logic [3:0] TAG_REPORT_SIZE  = 4'd7;
   localparam logic [3:0] TAG_REPORT_ID    = 4'd8;
   localparam logic [3:0] TAG_REPORT_COUNT = 4'd9;

   // Main item tags of the three report kinds.
   localparam logic [3:0] TAG_MAIN_INPUT   = 4'd8;
   localparam logic [3:0] TAG_MAIN_OUTPUT  = 4'd9;
   localparam logic [3:0] TAG_MAIN_FEATURE = 4'd11;

   // Size code that marks a malformed item.
   localparam logic [1:0] SIZE_INVALID = 2'd3;

   // Result kinds.
   localparam logic RESULT_BYTE    = 1'b0;
   localparam logic RESULT_SUMMARY = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_WANTED_KIND = 1'b0;
   localparam logic CSR_MAX_REPORT  = 1'b1;

   // Configuration reset values.
   localparam logic [3:0] WANTED_KIND_RESET = 4'd8;
   localparam logic [9:0] MAX_REPORT_RESET  = 10'd64;

   // Descriptor length saturates here; anything above the reportable maximum reads 0.
   localparam logic [8:0] DESC_SATURATE = 9'd256;
   localparam logic [8:0] DESC_REPORT_MAX = 9'd255;

   // One queued work entry: the bytes an item serializes to and an optional summary.
   typedef struct packed {
      logic [1:0] byte_count;
      logic       has_summary;
      logic [7:0] prefix;
      logic [7:0] data_low;
      logic [7:0] data_high;
      logic [9:0] report_bytes;
      logic [7:0] descriptor_bytes;
      logic       id_present;
      logic [7:0] report_id;
      logic       item_error;
      logic       length_overflow;
   } hrds_entry_type;

endpackage

`default_nettype wire

// ----- design/hrds_front.sv -----
// Front end of the HID report descriptor scanner: accepts items, tracks global
// state and configuration, and builds queue entries. Depends on hrds_pkg.
`default_nettype none

module hrds_front (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     csr_write_enable,
   input  wire                     csr_index,
   input  wire  [9:0]              csr_write_data,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire  [1:0]              req_item_type,
   input  wire  [3:0]              req_item_tag,
   input  wire  [1:0]              req_item_size,
   input  wire  [7:0]              req_data_low,
   input  wire  [7:0]              req_data_high,
   input  wire                     req_last_item,
   input  wire                     queue_full,
   output logic                    push,
   output hrds_pkg::hrds_entry_type push_entry
);
   import hrds_pkg::*;

   logic [3:0]  wanted_kind_ff, wanted_kind_in;
   logic [9:0]  max_report_ff, max_report_in;
   logic [7:0]  field_bits_ff, field_bits_in;
   logic [7:0]  field_count_ff, field_count_in;
   logic [15:0] product_ff, product_in;
   logic [9:0]  report_total_ff, report_total_in;
   logic [8:0]  desc_total_ff, desc_total_in;
   logic        id_seen_ff, id_seen_in;
   logic [7:0]  id_value_ff, id_value_in;
   logic        overflow_ff, overflow_in;
   logic        error_ff, error_in;

   logic        accept;
   logic [7:0]  data_value;
   logic        size_item, count_item, id_item, sum_item, bad_size, emit;
   logic [7:0]  mul_a, mul_b;
   logic [15:0] product_calc;
   logic [12:0] round_bytes;
   logic [13:0] report_sum;
   logic [9:0]  desc_sum;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   assign data_value = (req_item_size == 2'd0) ? 8'd0 : req_data_low;
   assign size_item  = (req_item_type == TYPE_GLOBAL) && (req_item_tag == TAG_REPORT_SIZE);
   assign count_item = (req_item_type == TYPE_GLOBAL) && (req_item_tag == TAG_REPORT_COUNT);
   assign id_item    = (req_item_type == TYPE_GLOBAL) && (req_item_tag == TAG_REPORT_ID);
   assign sum_item   = (req_item_type == TYPE_MAIN) && (req_item_tag == wanted_kind_ff)
                       && !overflow_ff;
   assign bad_size   = (req_item_size == SIZE_INVALID);
   assign emit       = !bad_size && !error_ff;

   // The product of size and count is kept registered, so a main item only
   // needs an add and a compare against it.
   assign mul_a        = size_item  ? data_value : field_bits_ff;
   assign mul_b        = count_item ? data_value : field_count_ff;
   assign product_calc = {8'd0, mul_a} * {8'd0, mul_b};

   assign round_bytes = 13'((17'(product_ff) + 17'd7) >> 3);
   assign report_sum  = 14'(report_total_ff) + 14'(round_bytes);
   assign desc_sum    = 10'(desc_total_ff) + 10'(req_item_size) + 10'd1;

   always_comb begin
      wanted_kind_in = wanted_kind_ff;
      max_report_in  = max_report_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_WANTED_KIND: wanted_kind_in = csr_write_data[3:0];
            CSR_MAX_REPORT:  max_report_in  = csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      field_bits_in   = size_item  ? data_value : field_bits_ff;
      field_count_in  = count_item ? data_value : field_count_ff;
      product_in      = (size_item || count_item) ? product_calc : product_ff;
      id_seen_in      = id_seen_ff;
      id_value_in     = id_value_ff;
      if (id_item && !id_seen_ff) begin
         id_seen_in  = 1'b1;
         id_value_in = data_value;
      end
      report_total_in = report_total_ff;
      overflow_in     = overflow_ff;
      if (sum_item) begin
         if (report_sum > 14'(max_report_ff)) begin
            report_total_in = 10'd0;
            overflow_in     = 1'b1;
         end else begin
            report_total_in = report_sum[9:0];
         end
      end
      desc_total_in = desc_total_ff;
      if (!bad_size) begin
         desc_total_in = (desc_sum > 10'(DESC_SATURATE)) ? DESC_SATURATE : desc_sum[8:0];
      end
      error_in = error_ff || bad_size;
   end

   always_comb begin
      push_entry.byte_count       = emit ? (req_item_size + 2'd1) : 2'd0;
      push_entry.has_summary      = req_last_item;
      push_entry.prefix           = {req_item_tag, req_item_type, req_item_size};
      push_entry.data_low         = req_data_low;
      push_entry.data_high        = req_data_high;
      push_entry.report_bytes     = overflow_in ? 10'd0 : report_total_in;
      push_entry.descriptor_bytes = (desc_total_in > DESC_REPORT_MAX) ? 8'd0
                                                                     : desc_total_in[7:0];
      push_entry.id_present       = id_seen_in;
      push_entry.report_id        = id_seen_in ? id_value_in : 8'd0;
      push_entry.item_error       = error_in;
      push_entry.length_overflow  = overflow_in;
      push = accept && (emit || req_last_item);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_kind_ff  <= WANTED_KIND_RESET;
         max_report_ff   <= MAX_REPORT_RESET;
         field_bits_ff   <= 8'd0;
         field_count_ff  <= 8'd0;
         product_ff      <= 16'd0;
         report_total_ff <= 10'd0;
         desc_total_ff   <= 9'd0;
         id_seen_ff      <= 1'b0;
         id_value_ff     <= 8'd0;
         overflow_ff     <= 1'b0;
         error_ff        <= 1'b0;
      end else begin
         wanted_kind_ff <= wanted_kind_in;
         max_report_ff  <= max_report_in;
         if (accept && req_last_item) begin
            // The summary has been taken from the updated state; start afresh.
            field_bits_ff   <= 8'd0;
            field_count_ff  <= 8'd0;
            product_ff      <= 16'd0;
            report_total_ff <= 10'd0;
            desc_total_ff   <= 9'd0;
            id_seen_ff      <= 1'b0;
            id_value_ff     <= 8'd0;
            overflow_ff     <= 1'b0;
            error_ff        <= 1'b0;
         end else if (accept) begin
            field_bits_ff   <= field_bits_in;
            field_count_ff  <= field_count_in;
            product_ff      <= product_in;
            report_total_ff <= report_total_in;
            desc_total_ff   <= desc_total_in;
            id_seen_ff      <= id_seen_in;
            id_value_ff     <= id_value_in;
            overflow_ff     <= overflow_in;
            error_ff        <= error_in;
         end
      end
   end

endmodule

`default_nettype wire

// ----- design/hrds_queue.sv -----
// Small register queue of work entries between the front and back ends.
// Depends on hrds_pkg for the entry type.
`default_nettype none

module hrds_queue #(
   parameter int DEPTH = 4
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   input  wire hrds_pkg::hrds_entry_type push_entry,
   output logic                     full,
   input  wire                      pop,
   output logic                     head_valid,
   output hrds_pkg::hrds_entry_type head_entry
);
   import hrds_pkg::*;

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]   LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

   hrds_entry_type slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == FULL_COUNT);
   assign head_valid = (count_ff != '0);
   assign head_entry = slots_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- design/hrds_back.sv -----
// Back end of the HID report descriptor scanner: walks each queued entry and
// drives one result per cycle, when not stalled, through the output register. Depends on hrds_pkg.
`default_nettype none

module hrds_back (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      head_valid,
   input  wire hrds_pkg::hrds_entry_type head_entry,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output logic                     rsp_result_kind,
   output logic [7:0]               rsp_byte_value,
   output logic [9:0]               rsp_report_bytes,
   output logic [7:0]               rsp_descriptor_bytes,
   output logic                     rsp_id_present,
   output logic [7:0]               rsp_report_id,
   output logic                     rsp_item_error,
   output logic                     rsp_length_overflow,
   output logic                     rsp_last_result
);
   import hrds_pkg::*;

   logic [1:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic       kind_ff, kind_in;
   logic [7:0] byte_ff, byte_in;
   logic [9:0] report_ff, report_in;
   logic [7:0] desc_ff, desc_in;
   logic       idn_ff, idn_in;
   logic [7:0] id_ff, id_in;
   logic       err_ff, err_in;
   logic       ovf_ff, ovf_in;
   logic       last_ff, last_in;

   logic       load, is_byte, final_step;
   logic [2:0] result_count;

   assign load         = head_valid && (!valid_ff || !rsp_stall);
   assign result_count = 3'(head_entry.byte_count) + 3'(head_entry.has_summary);
   assign final_step   = (3'(step_ff) + 3'd1 == result_count);
   assign is_byte      = (step_ff < head_entry.byte_count);
   assign pop          = load && final_step;

   always_comb begin
      step_in   = step_ff;
      valid_in  = valid_ff && rsp_stall;
      kind_in   = kind_ff;
      byte_in   = byte_ff;
      report_in = report_ff;
      desc_in   = desc_ff;
      idn_in    = idn_ff;
      id_in     = id_ff;
      err_in    = err_ff;
      ovf_in    = ovf_ff;
      last_in   = last_ff;
      if (load) begin
         valid_in = 1'b1;
         step_in  = final_step ? 2'd0 : step_ff + 2'd1;
         last_in  = final_step;
         if (is_byte) begin
            kind_in   = RESULT_BYTE;
            report_in = 10'd0;
            desc_in   = 8'd0;
            idn_in    = 1'b0;
            id_in     = 8'd0;
            err_in    = 1'b0;
            ovf_in    = 1'b0;
            case (step_ff)
               2'd0:    byte_in = head_entry.prefix;
               2'd1:    byte_in = head_entry.data_low;
               default: byte_in = head_entry.data_high;
            endcase
         end else begin
            kind_in   = RESULT_SUMMARY;
            byte_in   = 8'd0;
            report_in = head_entry.report_bytes;
            desc_in   = head_entry.descriptor_bytes;
            idn_in    = head_entry.id_present;
            id_in     = head_entry.report_id;
            err_in    = head_entry.item_error;
            ovf_in    = head_entry.length_overflow;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      byte_ff   <= byte_in;
      report_ff <= report_in;
      desc_ff   <= desc_in;
      idn_ff    <= idn_in;
      id_ff     <= id_in;
      err_ff    <= err_in;
      ovf_ff    <= ovf_in;
      last_ff   <= last_in;
   end

   assign rsp_valid            = valid_ff;
   assign rsp_result_kind      = kind_ff;
   assign rsp_byte_value       = byte_ff;
   assign rsp_report_bytes     = report_ff;
   assign rsp_descriptor_bytes = desc_ff;
   assign rsp_id_present       = idn_ff;
   assign rsp_report_id        = id_ff;
   assign rsp_item_error       = err_ff;
   assign rsp_length_overflow  = ovf_ff;
   assign rsp_last_result      = last_ff;

endmodule

`default_nettype wire

// ----- design/hid_report_descriptor_scanner_top.sv -----
// Top level of the HID report descriptor scanner: front end, entry queue and
// back end. Depends on hrds_pkg, hrds_front, hrds_queue and hrds_back.
//
//   Channel  Direction  Handshake             Contents
//   req_*    in         req_valid/req_stall   one short item: type, tag, size, data, last
//   rsp_*    out        rsp_valid/rsp_stall   one serialized byte or one summary
//   csr_*    in         csr_write_enable      register index and write data
//
// An item is accepted whenever the queue has a free slot, so items may arrive
// back to back. Each item produces zero to four results (size code plus one
// bytes, plus one for a summary), and the back end delivers one result per
// cycle while the output is not stalled; the output port is what sets the
// sustained rate. The first result of an item is held in a queue slot and then
// in the output register before it is offered. Reset is synchronous and clears
// all tracking state and restores the register defaults. A stall on the result
// side fills the queue and then stalls the item side.
`default_nettype none

module hid_report_descriptor_scanner_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        csr_write_enable,
   input  wire        csr_index,
   input  wire  [9:0] csr_write_data,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire  [1:0] req_item_type,
   input  wire  [3:0] req_item_tag,
   input  wire  [1:0] req_item_size,
   input  wire  [7:0] req_data_low,
   input  wire  [7:0] req_data_high,
   input  wire        req_last_item,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic       rsp_result_kind,
   output logic [7:0] rsp_byte_value,
   output logic [9:0] rsp_report_bytes,
   output logic [7:0] rsp_descriptor_bytes,
   output logic       rsp_id_present,
   output logic [7:0] rsp_report_id,
   output logic       rsp_item_error,
   output logic       rsp_length_overflow,
   output logic       rsp_last_result
);
   import hrds_pkg::*;

   // Entries travel from the front end to the back end through the queue; an
   // item that produces no result is absorbed by the front end alone.
   logic           push, queue_full, pop, head_valid;
   hrds_entry_type push_entry, head_entry;

   hrds_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_item_type    (req_item_type),
      .req_item_tag     (req_item_tag),
      .req_item_size    (req_item_size),
      .req_data_low     (req_data_low),
      .req_data_high    (req_data_high),
      .req_last_item    (req_last_item),
      .queue_full       (queue_full),
      .push             (push),
      .push_entry       (push_entry)
   );

   hrds_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // The back end owns the output register and takes the next result from the
   // queue only when that register is empty or its result is being taken.
   hrds_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head_valid           (head_valid),
      .head_entry           (head_entry),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_byte_value       (rsp_byte_value),
      .rsp_report_bytes     (rsp_report_bytes),
      .rsp_descriptor_bytes (rsp_descriptor_bytes),
      .rsp_id_present       (rsp_id_present),
      .rsp_report_id        (rsp_report_id),
      .rsp_item_error       (rsp_item_error),
      .rsp_length_overflow  (rsp_length_overflow),
      .rsp_last_result      (rsp_last_result)
   );

endmodule

`default_nettype wire

// ----- tb/sv/tb_hid_report_descriptor_scanner_top.sv -----
// Self-checking testbench for hid_report_descriptor_scanner_top: directed and random HID
// short items, predicted serialized bytes and descriptor summaries, random idling both sides.
// Depends on hrds_pkg and the scanner RTL.

module tb_hid_report_descriptor_scanner_top;
   import hrds_pkg::*;

   // One short item as it is offered on the request channel, plus two testbench-only
   // controls: hold it back until the response side has drained, and run without idling.
   typedef struct packed {
      logic [1:0] item_type;
      logic [3:0] item_tag;
      logic [1:0] item_size;
      logic [7:0] data_low;
      logic [7:0] data_high;
      logic       last_item;
      logic       wait_drain;
      logic       no_idle;
   } short_item_t;

   // One response, serialized byte or summary.
   typedef struct packed {
      logic       result_kind;
      logic [7:0] byte_value;
      logic [9:0] report_bytes;
      logic [7:0] descriptor_bytes;
      logic       id_present;
      logic [7:0] report_id;
      logic       item_error;
      logic       length_overflow;
      logic       last_result;
   } scan_result_t;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic       csr_index = CSR_WANTED_KIND;
   logic [9:0] csr_write_data = '0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_item_type = '0;
   logic [3:0] req_item_tag = '0;
   logic [1:0] req_item_size = '0;
   logic [7:0] req_data_low = '0;
   logic [7:0] req_data_high = '0;
   logic       req_last_item = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_result_kind;
   logic [7:0] rsp_byte_value;
   logic [9:0] rsp_report_bytes;
   logic [7:0] rsp_descriptor_bytes;
   logic       rsp_id_present;
   logic [7:0] rsp_report_id;
   logic       rsp_item_error;
   logic       rsp_length_overflow;
   logic       rsp_last_result;

   hid_report_descriptor_scanner_top u_top (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_item_type        (req_item_type),
      .req_item_tag         (req_item_tag),
      .req_item_size        (req_item_size),
      .req_data_low         (req_data_low),
      .req_data_high        (req_data_high),
      .req_last_item        (req_last_item),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_byte_value       (rsp_byte_value),
      .rsp_report_bytes     (rsp_report_bytes),
      .rsp_descriptor_bytes (rsp_descriptor_bytes),
      .rsp_id_present       (rsp_id_present),
      .rsp_report_id        (rsp_report_id),
      .rsp_item_error       (rsp_item_error),
      .rsp_length_overflow  (rsp_length_overflow),
      .rsp_last_result      (rsp_last_result)
   );

   // Items waiting to be offered, and results the scanner still owes us, oldest first.
   short_item_t  item_backlog[$];
   scan_result_t predicted_stream[$];

   // Copy of the two configuration registers, updated whenever the testbench writes one.
   logic [3:0] sum_kind = WANTED_KIND_RESET;
   logic [9:0] report_limit = MAX_REPORT_RESET;

   // Descriptor tracking state as the scanner should hold it.
   logic [7:0] field_bits;
   logic [7:0] field_count;
   logic [9:0] report_sum;
   logic [8:0] desc_len;
   logic       id_found;
   logic [7:0] first_id;
   logic       sum_overflow;
   logic       bad_size_seen;

   int  error_count = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   bit  req_taken = 1'b0;
   bit  quiet_mode = 1'b0;
   bit  fill_quiet = 1'b0;

   initial begin
      forever #10 clock = ~clock;
   end

   // The run is bounded by a fixed time far beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("[hid_report_descriptor_scanner_top] ERROR");
      $finish;
   end

   task automatic clear_tracking();
      field_bits    = '0;
      field_count   = '0;
      report_sum    = '0;
      desc_len      = '0;
      id_found      = 1'b0;
      first_id      = '0;
      sum_overflow  = 1'b0;
      bad_size_seen = 1'b0;
   endtask

   function automatic scan_result_t byte_result(input logic [7:0] value);
      scan_result_t r;
      r = '0;
      r.result_kind = RESULT_BYTE;
      r.byte_value  = value;
      return r;
   endfunction

   // Updates the tracking state for one accepted item and queues every result it
   // should produce: the serialized bytes, then the summary when the item ends a
   // descriptor. The final result of the item carries the last_result flag.
   task automatic serialize_and_tally(input short_item_t it);
      logic [7:0]   value;
      int unsigned  field_bytes;
      int unsigned  new_sum;
      int unsigned  new_len;
      scan_result_t batch[$];
      scan_result_t summary;
      value = (it.item_size == 2'd0) ? 8'd0 : it.data_low;
      if (it.item_type == TYPE_GLOBAL && it.item_tag == TAG_REPORT_SIZE)
         field_bits = value;
      if (it.item_type == TYPE_GLOBAL && it.item_tag == TAG_REPORT_COUNT)
         field_count = value;
      // Only the first report ID of a descriptor is kept.
      if (it.item_type == TYPE_GLOBAL && it.item_tag == TAG_REPORT_ID && !id_found) begin
         id_found = 1'b1;
         first_id = value;
      end
      if (it.item_type == TYPE_MAIN && it.item_tag == sum_kind && !sum_overflow) begin
         field_bytes = (int'(field_bits) * int'(field_count) + 7) / 8;
         new_sum = int'(report_sum) + field_bytes;
         if (new_sum > report_limit) begin
            report_sum   = '0;
            sum_overflow = 1'b1;
         end else begin
            report_sum = new_sum[9:0];
         end
      end
      // A malformed size code flags an error and serializes nothing; after that
      // no item serializes any more, though the lengths keep counting.
      if (it.item_size == SIZE_INVALID) begin
         bad_size_seen = 1'b1;
      end else begin
         new_len = int'(desc_len) + int'(it.item_size) + 1;
         if (new_len > DESC_SATURATE)
            new_len = 32'(DESC_SATURATE);
         desc_len = new_len[8:0];
         if (!bad_size_seen) begin
            batch.push_back(byte_result({it.item_tag, it.item_type, it.item_size}));
            if (it.item_size >= 2'd1)
               batch.push_back(byte_result(it.data_low));
            if (it.item_size == 2'd2)
               batch.push_back(byte_result(it.data_high));
         end
      end
      if (it.last_item) begin
         summary = '0;
         summary.result_kind      = RESULT_SUMMARY;
         summary.report_bytes     = sum_overflow ? 10'd0 : report_sum;
         summary.descriptor_bytes = (desc_len > DESC_REPORT_MAX) ? 8'd0 : desc_len[7:0];
         summary.id_present       = id_found;
         summary.report_id        = id_found ? first_id : 8'd0;
         summary.item_error       = bad_size_seen;
         summary.length_overflow  = sum_overflow;
         batch.push_back(summary);
         clear_tracking();
      end
      if (batch.size() > 0)
         batch[batch.size() - 1].last_result = 1'b1;
      foreach (batch[i])
         predicted_stream.push_back(batch[i]);
   endtask

   task automatic check_field(input string name, input logic [9:0] want,
                              input logic [9:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Most gaps are zero or short; now and then a long one.
   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         return 0;
      if (pick < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Request driver. Runs on the falling edge; the monitor flags an accepted item
   // at the rising edge, and here the next one is put up, or valid drops. The
   // local next-valid value keeps req_valid to one nonblocking write per edge, so
   // back-to-back items keep valid high without a glitch.
   always @(negedge clock) begin
      short_item_t nxt;
      logic        drive_valid;
      drive_valid = req_valid;
      if (req_taken) begin
         req_taken   = 1'b0;
         drive_valid = 1'b0;
      end
      if (!drive_valid && !reset) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (item_backlog.size() > 0 &&
                      (!item_backlog[0].wait_drain || predicted_stream.size() == 0)) begin
            nxt = item_backlog.pop_front();
            req_item_type <= nxt.item_type;
            req_item_tag  <= nxt.item_tag;
            req_item_size <= nxt.item_size;
            req_data_low  <= nxt.data_low;
            req_data_high <= nxt.data_high;
            req_last_item <= nxt.last_item;
            drive_valid   = 1'b1;
            quiet_mode    = nxt.no_idle;
            send_gap      = nxt.no_idle ? 0 : pick_gap();
         end
      end
      req_valid <= drive_valid;
   end

   // Response back-pressure: random stall and free runs, none while in a quiet stretch.
   always @(negedge clock) begin
      logic stall_next;
      if (stall_left > 0) begin
         stall_left--;
      end else begin
         stall_next = !quiet_mode && ($urandom_range(0, 2) == 0);
         stall_left = stall_next ? pick_gap() : $urandom_range(0, 5);
         rsp_stall <= stall_next;
      end
   end

   // Monitor. At each rising edge an accepted request feeds the predictor and an
   // accepted response is compared with the oldest prediction.
   always @(posedge clock) begin
      short_item_t  seen;
      scan_result_t want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            seen = '0;
            seen.item_type = req_item_type;
            seen.item_tag  = req_item_tag;
            seen.item_size = req_item_size;
            seen.data_low  = req_data_low;
            seen.data_high = req_data_high;
            seen.last_item = req_last_item;
            serialize_and_tally(seen);
            req_taken = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_stream.size() == 0) begin
               $display("%0t: unexpected result: expected none, got kind %0d byte %0d",
                        $time, rsp_result_kind, rsp_byte_value);
               error_count++;
            end else begin
               want = predicted_stream.pop_front();
               check_field("result_kind", 10'(want.result_kind), 10'(rsp_result_kind));
               check_field("byte_value", 10'(want.byte_value), 10'(rsp_byte_value));
               check_field("report_bytes", want.report_bytes, rsp_report_bytes);
               check_field("descriptor_bytes", 10'(want.descriptor_bytes),
                           10'(rsp_descriptor_bytes));
               check_field("id_present", 10'(want.id_present), 10'(rsp_id_present));
               check_field("report_id", 10'(want.report_id), 10'(rsp_report_id));
               check_field("item_error", 10'(want.item_error), 10'(rsp_item_error));
               check_field("length_overflow", 10'(want.length_overflow),
                           10'(rsp_length_overflow));
               check_field("last_result", 10'(want.last_result), 10'(rsp_last_result));
            end
         end
      end
   end

   task automatic add_item(input logic [1:0] ty, input logic [3:0] tg, input logic [1:0] sz,
                           input logic [7:0] lo, input logic [7:0] hi, input logic fin,
                           input logic drain);
      short_item_t it;
      it.item_type  = ty;
      it.item_tag   = tg;
      it.item_size  = sz;
      it.data_low   = lo;
      it.data_high  = hi;
      it.last_item  = fin;
      it.wait_drain = drain;
      it.no_idle    = fill_quiet;
      item_backlog.push_back(it);
   endtask

   // Waits on rising edges, where the backlog and req_valid are stable, until
   // everything has been offered, accepted and answered. Items that produce no
   // result never enter the scanner's queue; the front end absorbs them.
   task automatic wait_drained();
      while (item_backlog.size() != 0 || req_valid || predicted_stream.size() != 0)
         @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic write_register(input logic idx, input logic [9:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_WANTED_KIND)
         sum_kind = value[3:0];
      else
         report_limit = value;
   endtask

   // A descriptor that mostly looks like a real one: report size and count globals,
   // report IDs, main items on the usual report tags, locals, with some noise and the
   // odd malformed item mixed in. Sizes and counts are mostly small so that sums
   // build up over several main items before reaching the limit.
   task automatic random_descriptor(input int n_items);
      int         pick;
      logic [1:0] ty;
      logic [3:0] tg;
      logic [1:0] sz;
      logic [7:0] lo;
      logic [7:0] hi;
      logic [3:0] main_tags[7] = '{4'd0, TAG_MAIN_INPUT, TAG_MAIN_OUTPUT, 4'd10,
                                   TAG_MAIN_FEATURE, 4'd12, 4'd15};
      fill_quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n_items; i++) begin
         pick = $urandom_range(0, 99);
         lo = 8'($urandom_range(0, 255));
         hi = 8'($urandom_range(0, 255));
         sz = 2'($urandom_range(1, 2));
         if (pick < 30) begin
            ty = TYPE_GLOBAL;
            tg = (pick < 15) ? TAG_REPORT_SIZE : TAG_REPORT_COUNT;
            if ($urandom_range(0, 9) != 0)
               lo = 8'($urandom_range(0, 16));
            if ($urandom_range(0, 9) == 0)
               sz = 2'd0;
         end else if (pick < 38) begin
            ty = TYPE_GLOBAL;
            tg = TAG_REPORT_ID;
         end else if (pick < 62) begin
            ty = TYPE_MAIN;
            tg = main_tags[$urandom_range(0, 6)];
            sz = 2'($urandom_range(0, 2));
         end else if (pick < 75) begin
            ty = TYPE_LOCAL;
            tg = 4'($urandom_range(0, 15));
            sz = 2'($urandom_range(0, 2));
         end else begin
            ty = 2'($urandom_range(0, 3));
            tg = 4'($urandom_range(0, 15));
            sz = (pick < 96) ? 2'($urandom_range(0, 2)) : SIZE_INVALID;
         end
         add_item(ty, tg, sz, lo, hi, i == n_items - 1, $urandom_range(0, 39) == 0);
      end
   endtask

   // A long descriptor of two-byte items only, used to push the descriptor
   // length past the largest reportable value.
   task automatic long_descriptor(input int n_items);
      for (int i = 0; i < n_items; i++)
         add_item(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), 2'd2,
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  i == n_items - 1, 1'b0);
   endtask

   initial begin
      clear_tracking();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part under the reset configuration: input reports, limit of 64.
      // A plain descriptor: size 8, count 4, a report ID, then a second ID that
      // must be ignored, input mains that add up, an output main that does not,
      // a local and a reserved item. The last one waits for the pipeline to drain.
      add_item(TYPE_GLOBAL, TAG_REPORT_SIZE, 2'd1, 8'd8, 8'h00, 1'b0, 1'b0);
      add_item(TYPE_GLOBAL, TAG_REPORT_COUNT, 2'd1, 8'd4, 8'hFF, 1'b0, 1'b0);
      add_item(TYPE_GLOBAL, TAG_REPORT_ID, 2'd1, 8'hAA, 8'h00, 1'b0, 1'b0);
      add_item(TYPE_GLOBAL, TAG_REPORT_ID, 2'd2, 8'h55, 8'h01, 1'b0, 1'b0);
      add_item(TYPE_MAIN, TAG_MAIN_INPUT, 2'd1, 8'h02, 8'h00, 1'b0, 1'b0);
      add_item(TYPE_MAIN, TAG_MAIN_OUTPUT, 2'd0, 8'hFF, 8'hFF, 1'b0, 1'b0);
      add_item(TYPE_LOCAL, 4'd0, 2'd0, 8'h00, 8'h00, 1'b0, 1'b0);
      add_item(TYPE_RESERVED, 4'd15, 2'd2, 8'hFF, 8'hFF, 1'b0, 1'b0);
      add_item(TYPE_MAIN, TAG_MAIN_INPUT, 2'd0, 8'h00, 8'h00, 1'b1, 1'b1);
      // Zero-size data reads as zero, then a huge size times count overflows the
      // limit, and a later main item must not add anything more.
      add_item(TYPE_GLOBAL, TAG_REPORT_SIZE, 2'd0, 8'h33, 8'h00, 1'b0, 1'b0);
      add_item(TYPE_GLOBAL, TAG_REPORT_COUNT, 2'd1, 8'hFF, 8'h00, 1'b0, 1'b0);
      add_item(TYPE_MAIN, TAG_MAIN_INPUT, 2'd0, 8'h00, 8'h00, 1'b0, 1'b0);
      add_item(TYPE_GLOBAL, TAG_REPORT_SIZE, 2'd2, 8'hFF, 8'h00, 1'b0, 1'b0);
      add_item(TYPE_MAIN, TAG_MAIN_INPUT, 2'd0, 8'h00, 8'h00, 1'b0, 1'b0);
      add_item(TYPE_GLOBAL, TAG_REPORT_SIZE, 2'd1, 8'h01, 8'h00, 1'b0, 1'b0);
      add_item(TYPE_MAIN, TAG_MAIN_INPUT, 2'd0, 8'h00, 8'h00, 1'b0, 1'b0);
      add_item(TYPE_GLOBAL, TAG_REPORT_COUNT, 2'd2, 8'h12, 8'h34, 1'b1, 1'b0);
      // A malformed item first: it still sets the report ID and the sizes, but
      // from here on the descriptor serializes nothing and only the summary comes.
      add_item(TYPE_GLOBAL, TAG_REPORT_ID, SIZE_INVALID, 8'h77, 8'h00, 1'b0, 1'b0);
      add_item(TYPE_GLOBAL, TAG_REPORT_SIZE, SIZE_INVALID, 8'h10, 8'hFF, 1'b0, 1'b0);
      add_item(TYPE_GLOBAL, TAG_REPORT_COUNT, 2'd1, 8'h02, 8'h00, 1'b0, 1'b0);
      add_item(TYPE_MAIN, TAG_MAIN_INPUT, SIZE_INVALID, 8'h00, 8'h00, 1'b0, 1'b0);
      add_item(TYPE_GLOBAL, TAG_REPORT_ID, 2'd1, 8'h01, 8'h00, 1'b1, 1'b0);
      // One-item descriptors: malformed and last at once, then empty data and last.
      add_item(TYPE_MAIN, 4'd0, SIZE_INVALID, 8'hFF, 8'hFF, 1'b1, 1'b0);
      add_item(TYPE_MAIN, 4'd12, 2'd0, 8'h00, 8'h00, 1'b1, 1'b0);
      wait_drained();

      // Output reports with the widest limit.
      write_register(CSR_WANTED_KIND, 10'(TAG_MAIN_OUTPUT));
      write_register(CSR_MAX_REPORT, 10'd1023);
      repeat (2) random_descriptor($urandom_range(3, 10));
      wait_drained();

      // Feature reports with a zero limit: any nonzero sum overflows at once.
      write_register(CSR_WANTED_KIND, 10'(TAG_MAIN_FEATURE));
      write_register(CSR_MAX_REPORT, 10'd0);
      repeat (2) random_descriptor($urandom_range(3, 10));
      wait_drained();

      // Highest tag, widest limit; the long descriptor runs without idling and
      // crosses the length saturation edge.
      write_register(CSR_WANTED_KIND, 10'd15);
      write_register(CSR_MAX_REPORT, 10'd1023);
      fill_quiet = 1'b1;
      long_descriptor(86);
      fill_quiet = 1'b0;
      random_descriptor($urandom_range(3, 10));
      wait_drained();

      // Lowest tag and a mid-range limit.
      write_register(CSR_WANTED_KIND, 10'd0);
      write_register(CSR_MAX_REPORT, 10'($urandom_range(16, 300)));
      repeat (2) random_descriptor($urandom_range(3, 10));
      wait_drained();

      if (error_count == 0)
         $display("[hid_report_descriptor_scanner_top] OK");
      else
         $display("[hid_report_descriptor_scanner_top] ERROR");
      $finish;
   end

endmodule
